FILE: hw/rtl/bct_pkg.sv
// shared types, constants and helper functions of the binary contour tracer
// no dependencies; used by every module of the block
`default_nettype none

package bct_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int PADDR_W     = 4;

  localparam logic [6:0]  RST_WIDTH     = 7'd64;
  localparam logic [6:0]  RST_HEIGHT    = 7'd64;
  localparam logic [8:0]  RST_THRESHOLD = 9'd128;
  localparam logic [12:0] RST_MAXPTS    = 13'd4096;
  localparam logic [12:0] POINT_LIMIT   = 13'd4096;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_MAXPTS    = 2'd3;

  localparam logic [1:0] PH_LOADING   = 2'd0;
  localparam logic [1:0] PH_FOLLOWING = 2'd1;
  localparam logic [1:0] PH_ENDED     = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [2:0] DIR_BACK = 3'd5;

  typedef struct packed {
    logic [6:0]  image_width;
    logic [6:0]  image_height;
    logic [8:0]  gray_threshold;
    logic [12:0] max_points;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic start_scan;
    logic start_nbr;
    logic commit_scan;
    logic commit_nbr;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [1:0] phase;
    logic       limit_zero;
    logic       limit_reached;
    logic       hit;
    logic       miss;
  } status_t;

  function automatic logic [6:0] eff_width(input logic [6:0] w);
    if (w == 7'd0) return 7'd1;
    if (w > 7'(MAX_WIDTH)) return 7'(MAX_WIDTH);
    return w;
  endfunction

  function automatic logic [6:0] eff_height(input logic [6:0] h);
    if (h == 7'd0) return 7'd1;
    if (h > 7'(MAX_HEIGHT)) return 7'(MAX_HEIGHT);
    return h;
  endfunction

  function automatic logic [12:0] eff_limit(input logic [12:0] m);
    return (m > POINT_LIMIT) ? POINT_LIMIT : m;
  endfunction

  // column step per direction, clockwise from east
  function automatic logic [1:0] step_dx(input logic [2:0] d);
    case (d)
      3'd0, 3'd1, 3'd7: return 2'b01;
      3'd3, 3'd4, 3'd5: return 2'b11;
      default:          return 2'b00;
    endcase
  endfunction

  // row step per direction
  function automatic logic [1:0] step_dy(input logic [2:0] d);
    case (d)
      3'd1, 3'd2, 3'd3: return 2'b01;
      3'd5, 3'd6, 3'd7: return 2'b11;
      default:          return 2'b00;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/binary_contour_tracer_unit.sv
// top level of the binary contour tracer: register file, controller, datapath
// depends on bct_pkg, bct_regs, bct_ctrl, bct_dp
`default_nettype none

// A request is taken when start is high and busy is low. A load request (opcode 0)
// writes one thresholded pixel and gives no result. A step request gives exactly
// one result, shown for one cycle with out_strobe, and the receiver cannot hold it
// off. Probes of the one-bit pixel store run through a two-stage pipeline (address,
// registered read) at one probe per cycle. A neighbor step probes up to eight
// neighbors in turn, a step that ends the trace may do so without probing, and the
// first step scans the image in raster order until it finds a set pixel. The store
// needs no clearing pass after reset: a fill count makes never-loaded pixels read
// as clear.
module binary_contour_tracer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic [7:0]                  in_red,
  input  wire logic [7:0]                  in_green,
  input  wire logic [7:0]                  in_blue,
  output logic                             out_strobe,
  output logic [5:0]                       out_point_x,
  output logic [5:0]                       out_point_y,
  output logic [11:0]                      out_point_index,
  output logic                             out_point_valid,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bct_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  bct_pkg::cfg_t    cfg;
  bct_pkg::cmd_t    cmd;
  bct_pkg::status_t status;

  bct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bct_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  bct_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .status          (status),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_index (out_point_index),
    .out_point_valid (out_point_valid),
    .out_strobe      (out_strobe)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bct_regs.sv
// configuration register file behind the apb-style port
// depends on bct_pkg
`default_nettype none

module bct_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bct_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output bct_pkg::cfg_t                    cfg
);

  bct_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        bct_pkg::REG_WIDTH:     cfg_nxt.image_width    = pwdata[6:0];
        bct_pkg::REG_HEIGHT:    cfg_nxt.image_height   = pwdata[6:0];
        bct_pkg::REG_THRESHOLD: cfg_nxt.gray_threshold = pwdata[8:0];
        bct_pkg::REG_MAXPTS:    cfg_nxt.max_points     = pwdata[12:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bct_pkg::REG_WIDTH:     prdata = {25'd0, cfg_r.image_width};
      bct_pkg::REG_HEIGHT:    prdata = {25'd0, cfg_r.image_height};
      bct_pkg::REG_THRESHOLD: prdata = {23'd0, cfg_r.gray_threshold};
      bct_pkg::REG_MAXPTS:    prdata = {19'd0, cfg_r.max_points};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= bct_pkg::RST_WIDTH;
      cfg_r.image_height   <= bct_pkg::RST_HEIGHT;
      cfg_r.gray_threshold <= bct_pkg::RST_THRESHOLD;
      cfg_r.max_points     <= bct_pkg::RST_MAXPTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bct_ctrl.sv
// controller state machine: sequences load, scan, neighbor search and end
// depends on bct_pkg
`default_nettype none

module bct_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire bct_pkg::status_t status,
  output logic                  busy,
  output bct_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_NBR  = 3'd4;
  localparam logic [2:0] ST_END  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        if (status.opcode == bct_pkg::OP_LOAD) begin
          state_nxt = ST_LOAD;
        end else begin
          case (status.phase)
            bct_pkg::PH_LOADING: begin
              if (status.limit_zero) begin
                state_nxt = ST_END;
              end else begin
                cmd.start_scan = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
            bct_pkg::PH_FOLLOWING: begin
              if (status.limit_reached) begin
                state_nxt = ST_END;
              end else begin
                cmd.start_nbr = 1'b1;
                state_nxt     = ST_NBR;
              end
            end
            default: state_nxt = ST_END;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.commit_scan = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (status.miss) begin
          state_nxt = ST_END;
        end
      end
      ST_NBR: begin
        if (status.hit) begin
          cmd.commit_nbr = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (status.miss) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        cmd.emit_end = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bct_dp.sv
// datapath: pixel store, trace state, two-stage probe pipeline, result registers
// depends on bct_pkg
`default_nettype none

module bct_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bct_pkg::cfg_t cfg,
  input  wire bct_pkg::cmd_t cmd,
  input  wire logic          in_opcode,
  input  wire logic [7:0]    in_red,
  input  wire logic [7:0]    in_green,
  input  wire logic [7:0]    in_blue,
  output bct_pkg::status_t   status,
  output logic [5:0]         out_point_x,
  output logic [5:0]         out_point_y,
  output logic [11:0]        out_point_index,
  output logic               out_point_valid,
  output logic               out_strobe
);

  localparam int AW = bct_pkg::STORE_AW;

  logic pix_mem [bct_pkg::STORE_DEPTH];

  // captured request
  logic       op_r;
  logic [7:0] red_r, green_r, blue_r;

  // trace state
  logic [1:0]  phase_r, phase_nxt;
  logic [12:0] la_r, la_nxt;
  logic [12:0] fill_r, fill_nxt;
  logic [5:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic [5:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [2:0]  sd_r, sd_nxt;
  logic [12:0] pts_r, pts_nxt;

  // probe generator
  logic        gen_on_r, gen_on_nxt;
  logic        mode_scan_r, mode_scan_nxt;
  logic [12:0] sa_r, sa_nxt;
  logic [5:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [2:0]  ni_r, ni_nxt;

  // probe pipeline
  logic          p1_v_r, p1_ok_r, p1_last_r;
  logic [AW-1:0] p1_addr_r;
  logic [5:0]    p1_x_r, p1_y_r;
  logic [2:0]    p1_dir_r;
  logic          p2_v_r, p2_ok_r, p2_last_r;
  logic [5:0]    p2_x_r, p2_y_r;
  logic [2:0]    p2_dir_r;
  logic          rd_r;

  // results
  logic        os_r, os_nxt;
  logic [5:0]  ox_out_r, ox_out_nxt, oy_out_r, oy_out_nxt;
  logic [11:0] oi_r, oi_nxt;
  logic        ov_r, ov_nxt;

  logic [6:0]  w_eff, h_eff;
  logic [12:0] wh, lim;
  logic        flush;

  logic [9:0]  rgb_sum;
  logic [10:0] thr3;
  logic        pix_set;
  logic [12:0] la_eff;
  logic        wr_en;

  logic [2:0]    n_dir;
  logic [1:0]    n_dx, n_dy;
  logic [7:0]    n_x, n_y;
  logic          n_inb;
  logic [12:0]   n_addr;
  logic          g_ok, g_last;
  logic [AW-1:0] g_addr;
  logic [5:0]    g_x, g_y;
  logic          hit, miss;

  assign w_eff = bct_pkg::eff_width(cfg.image_width);
  assign h_eff = bct_pkg::eff_height(cfg.image_height);
  assign wh    = 13'({6'd0, w_eff} * {6'd0, h_eff});
  assign lim   = bct_pkg::eff_limit(cfg.max_points);
  assign flush = cmd.commit_scan | cmd.commit_nbr | cmd.emit_end;

  // floor(sum/3) < t is the same as sum < 3t
  assign rgb_sum = 10'(red_r) + 10'(green_r) + 10'(blue_r);
  assign thr3    = {1'b0, cfg.gray_threshold, 1'b0} + 11'(cfg.gray_threshold);
  assign pix_set = ({1'b0, rgb_sum} < thr3);
  assign la_eff  = (phase_r != bct_pkg::PH_LOADING) ? 13'd0 : la_r;
  assign wr_en   = cmd.load & (la_eff < wh);

  // neighbor probe
  assign n_dir  = sd_r + ni_r;
  assign n_dx   = bct_pkg::step_dx(n_dir);
  assign n_dy   = bct_pkg::step_dy(n_dir);
  assign n_x    = {2'b00, cx_r} + {{6{n_dx[1]}}, n_dx};
  assign n_y    = {2'b00, cy_r} + {{6{n_dy[1]}}, n_dy};
  assign n_inb  = !n_x[7] && (n_x[6:0] < w_eff) && !n_y[7] && (n_y[6:0] < h_eff);
  assign n_addr = 13'({7'd0, n_y[5:0]} * {6'd0, w_eff}) + {7'd0, n_x[5:0]};

  always_comb begin
    if (mode_scan_r) begin
      g_ok   = (sa_r < fill_r);
      g_last = ((sa_r + 13'd1) == wh);
      g_addr = sa_r[AW-1:0];
      g_x    = sx_r;
      g_y    = sy_r;
    end else begin
      g_ok   = n_inb && (n_addr < fill_r);
      g_last = (ni_r == 3'd7);
      g_addr = n_addr[AW-1:0];
      g_x    = n_x[5:0];
      g_y    = n_y[5:0];
    end
  end

  assign hit  = p2_v_r & p2_ok_r & rd_r;
  assign miss = p2_v_r & p2_last_r & ~hit;

  assign status.opcode        = op_r;
  assign status.phase         = phase_r;
  assign status.limit_zero    = (lim == 13'd0);
  assign status.limit_reached = (pts_r >= lim);
  assign status.hit           = hit;
  assign status.miss          = miss;

  // generator stepping
  always_comb begin
    gen_on_nxt    = gen_on_r;
    mode_scan_nxt = mode_scan_r;
    sa_nxt        = sa_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    ni_nxt        = ni_r;
    if (cmd.start_scan) begin
      gen_on_nxt    = 1'b1;
      mode_scan_nxt = 1'b1;
      sa_nxt        = 13'd0;
      sx_nxt        = 6'd0;
      sy_nxt        = 6'd0;
    end else if (cmd.start_nbr) begin
      gen_on_nxt    = 1'b1;
      mode_scan_nxt = 1'b0;
      ni_nxt        = 3'd0;
    end else if (flush) begin
      gen_on_nxt = 1'b0;
    end else if (gen_on_r) begin
      if (g_last) begin
        gen_on_nxt = 1'b0;
      end
      if (mode_scan_r) begin
        sa_nxt = sa_r + 13'd1;
        if ((7'(sx_r) + 7'd1) == w_eff) begin
          sx_nxt = 6'd0;
          sy_nxt = sy_r + 6'd1;
        end else begin
          sx_nxt = sx_r + 6'd1;
        end
      end else begin
        ni_nxt = ni_r + 3'd1;
      end
    end
  end

  // trace state and results
  always_comb begin
    phase_nxt  = phase_r;
    la_nxt     = la_r;
    fill_nxt   = fill_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    sd_nxt     = sd_r;
    pts_nxt    = pts_r;
    os_nxt     = 1'b0;
    ox_out_nxt = ox_out_r;
    oy_out_nxt = oy_out_r;
    oi_nxt     = oi_r;
    ov_nxt     = ov_r;
    if (cmd.load) begin
      phase_nxt = bct_pkg::PH_LOADING;
      la_nxt    = la_eff;
      if (wr_en) begin
        la_nxt = la_eff + 13'd1;
        if ((la_eff + 13'd1) > fill_r) begin
          fill_nxt = la_eff + 13'd1;
        end
      end
    end
    if (cmd.commit_scan) begin
      cx_nxt     = p2_x_r;
      cy_nxt     = p2_y_r;
      ox_nxt     = p2_x_r;
      oy_nxt     = p2_y_r;
      sd_nxt     = 3'd0;
      pts_nxt    = 13'd1;
      phase_nxt  = bct_pkg::PH_FOLLOWING;
      os_nxt     = 1'b1;
      ox_out_nxt = p2_x_r;
      oy_out_nxt = p2_y_r;
      oi_nxt     = 12'd0;
      ov_nxt     = 1'b1;
    end
    if (cmd.commit_nbr) begin
      cx_nxt = p2_x_r;
      cy_nxt = p2_y_r;
      sd_nxt = p2_dir_r + bct_pkg::DIR_BACK;
      os_nxt = 1'b1;
      if ((p2_x_r == ox_r) && (p2_y_r == oy_r)) begin
        phase_nxt  = bct_pkg::PH_ENDED;
        ox_out_nxt = 6'd0;
        oy_out_nxt = 6'd0;
        oi_nxt     = 12'd0;
        ov_nxt     = 1'b0;
      end else begin
        ox_out_nxt = p2_x_r;
        oy_out_nxt = p2_y_r;
        oi_nxt     = pts_r[11:0];
        ov_nxt     = 1'b1;
        pts_nxt    = pts_r + 13'd1;
      end
    end
    if (cmd.emit_end) begin
      phase_nxt  = bct_pkg::PH_ENDED;
      os_nxt     = 1'b1;
      ox_out_nxt = 6'd0;
      oy_out_nxt = 6'd0;
      oi_nxt     = 12'd0;
      ov_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[la_eff[AW-1:0]] <= pix_set;
    end
    rd_r <= pix_mem[p1_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_opcode;
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
    end
    p1_ok_r   <= g_ok;
    p1_last_r <= g_last;
    p1_addr_r <= g_addr;
    p1_x_r    <= g_x;
    p1_y_r    <= g_y;
    p1_dir_r  <= n_dir;
    p2_ok_r   <= p1_ok_r;
    p2_last_r <= p1_last_r;
    p2_x_r    <= p1_x_r;
    p2_y_r    <= p1_y_r;
    p2_dir_r  <= p1_dir_r;
    ox_out_r  <= ox_out_nxt;
    oy_out_r  <= oy_out_nxt;
    oi_r      <= oi_nxt;
    ov_r      <= ov_nxt;
    sa_r      <= sa_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    ni_r      <= ni_nxt;
    mode_scan_r <= mode_scan_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= bct_pkg::PH_LOADING;
      la_r     <= 13'd0;
      fill_r   <= 13'd0;
      cx_r     <= 6'd0;
      cy_r     <= 6'd0;
      ox_r     <= 6'd0;
      oy_r     <= 6'd0;
      sd_r     <= 3'd0;
      pts_r    <= 13'd0;
      gen_on_r <= 1'b0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      os_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      la_r     <= la_nxt;
      fill_r   <= fill_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      sd_r     <= sd_nxt;
      pts_r    <= pts_nxt;
      gen_on_r <= gen_on_nxt;
      p1_v_r   <= gen_on_r & ~flush;
      p2_v_r   <= p1_v_r & ~flush;
      os_r     <= os_nxt;
    end
  end

  assign out_strobe      = os_r;
  assign out_point_x     = ox_out_r;
  assign out_point_y     = oy_out_r;
  assign out_point_index = oi_r;
  assign out_point_valid = ov_r;

endmodule

`default_nettype wire
